// ===== src/sbed_pkg.sv =====
// Shared types and constants for the spectral band energy detector.
// No dependencies; imported by every module of the block.
package sbed_pkg;

    // Field widths of the result item, configuration words and samples
    localparam int POWER_W  = 14;
    localparam int ENERGY_W = 23;
    localparam int POS_W    = 9;
    localparam int FREQ_W   = 25;
    localparam int HZ_W     = 16;
    localparam int CFG_W    = 32;
    localparam int SAMPLE_W = 16;
    localparam int SQ_W     = 2 * SAMPLE_W;

    // Saturation limits
    localparam logic [POWER_W-1:0]  POWER_MAX  = 14'h3FFF;
    localparam logic [ENERGY_W-1:0] ENERGY_MAX = 23'h7FFFFF;

    // Register reset values
    localparam logic [8:0]       BAND_FIRST_RST = 9'd10;
    localparam logic [9:0]       BAND_END_RST   = 10'd100;
    localparam logic [CFG_W-1:0] MIN_ENERGY_RST = 32'd100;
    localparam logic [CFG_W-1:0] MIN_FREQ_RST   = 32'd10000;
    localparam logic [HZ_W-1:0]  HZ_PER_BIN_RST = 16'd1000;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_BAND_FIRST = 3'd0,
        CFG_BAND_END   = 3'd1,
        CFG_MIN_ENERGY = 3'd2,
        CFG_MIN_FREQ   = 3'd3,
        CFG_HZ_PER_BIN = 3'd4
    } cfg_idx_t;

    // Per-item control carried down the power pipeline
    typedef struct packed {
        logic             rd;       // read item
        logic             rd_ok;    // read index inside the table
        logic             in_band;  // bin counts toward energy and peak
        logic             store;    // bin is written to the table
        logic             last;     // final bin of the frame
        logic [POS_W-1:0] pos;      // bin index for the peak position
    } item_ctrl_t;

    // Result fields handed from the table stage to the output register
    typedef struct packed {
        logic                rd;
        logic                rd_ok;
        logic [ENERGY_W-1:0] energy;
        logic [POWER_W-1:0]  peak;
        logic [POS_W-1:0]    pos;
        logic [POWER_W-1:0]  data;
    } result_t;

endpackage

// ===== src/spectral_band_energy_detector.sv =====
// Spectral band energy detector: bin counter, configuration registers, output stage.
// Path: an item passes the power stages, the table stage, then the output register.
// Throughput: one item per cycle while the output is not stalled; each stage holds
// one item; table write and read share the single-port stage after the power sum.
// Reset: registers return to their defaults, counter, energy and peak clear;
// the power table has no reset and no clearing pass.
module spectral_band_energy_detector
    import sbed_pkg::*;
#(
    parameter int TABLE_DEPTH = 128,
    parameter int FRAME_BINS  = 512,
    parameter int BIN_SHIFT   = 9
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    // configuration
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [2:0]                 cfg_index,
    input  logic [CFG_W-1:0]           cfg_data,
    // input item
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic                       mode,
    input  logic signed [SAMPLE_W-1:0] bin_real,
    input  logic signed [SAMPLE_W-1:0] bin_imag,
    input  logic                       last_bin,
    input  logic [6:0]                 read_index,
    // result item
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic                       detect,
    output logic [ENERGY_W-1:0]        band_energy,
    output logic [POWER_W-1:0]         peak_level,
    output logic [POS_W-1:0]           peak_index,
    output logic [FREQ_W-1:0]          peak_frequency,
    output logic [POWER_W-1:0]         table_value
);

    localparam int TAW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW   = $clog2(FRAME_BINS);
    localparam int CMPW = (CW > 10) ? CW : 10;

    // configuration registers
    logic [8:0]       band_first_reg;
    logic [9:0]       band_end_reg;
    logic [CFG_W-1:0] min_energy_reg;
    logic [CFG_W-1:0] min_freq_reg;
    logic [HZ_W-1:0]  hz_reg;

    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             accept;
    logic             in_ready;
    logic [CMPW-1:0]  cnt_x, offset;
    item_ctrl_t       ctrl;
    logic [TAW-1:0]   addr;

    logic               pw_valid, pw_ready;
    item_ctrl_t         pw_ctrl;
    logic [TAW-1:0]     pw_addr;
    logic [POWER_W-1:0] pw_power;

    logic               res_valid, res_ready;
    result_t            res;

    logic               out_v_reg;
    logic               detect_reg;
    logic [ENERGY_W-1:0] energy_reg;
    logic [POWER_W-1:0] peak_reg, tval_reg;
    logic [POS_W-1:0]   pos_reg;
    logic [FREQ_W-1:0]  freq_reg;
    logic [FREQ_W-1:0]  freq;
    logic               det;

    assign cfg_ready = 1'b1;
    assign in_stall  = !in_ready;
    assign accept    = in_valid && in_ready;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            band_first_reg <= BAND_FIRST_RST;
            band_end_reg   <= BAND_END_RST;
            min_energy_reg <= MIN_ENERGY_RST;
            min_freq_reg   <= MIN_FREQ_RST;
            hz_reg         <= HZ_PER_BIN_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_BAND_FIRST: band_first_reg <= cfg_data[8:0];
                CFG_BAND_END:   band_end_reg   <= cfg_data[9:0];
                CFG_MIN_ENERGY: min_energy_reg <= cfg_data;
                CFG_MIN_FREQ:   min_freq_reg   <= cfg_data;
                CFG_HZ_PER_BIN: hz_reg         <= cfg_data[HZ_W-1:0];
                default: ;
            endcase
        end
    end

    // band decode against the bin counter
    always_comb
    begin
        cnt_x         = CMPW'(cnt_reg);
        offset        = cnt_x - CMPW'(band_first_reg);
        ctrl.rd       = mode;
        ctrl.rd_ok    = CMPW'(read_index) < CMPW'(TABLE_DEPTH);
        ctrl.in_band  = (cnt_x >= CMPW'(band_first_reg)) && (cnt_x < CMPW'(band_end_reg));
        ctrl.store    = ctrl.in_band && (offset < CMPW'(TABLE_DEPTH));
        ctrl.last     = last_bin;
        ctrl.pos      = POS_W'(cnt_reg);
        addr          = mode ? TAW'(read_index) : TAW'(offset);
    end

    // bin counter: reads do not advance it, frame end clears it
    always_comb
    begin
        cnt_next = cnt_reg;
        if (accept && !mode)
        begin
            if (last_bin || (cnt_reg == CW'(FRAME_BINS - 1)))
            begin
                cnt_next = '0;
            end
            else
            begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    sbed_power #(
        .BIN_SHIFT (BIN_SHIFT),
        .TAW       (TAW)
    ) u_power (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_load  (in_valid),
        .in_ready (in_ready),
        .in_ctrl  (ctrl),
        .in_addr  (addr),
        .in_real  (bin_real),
        .in_imag  (bin_imag),
        .pw_valid (pw_valid),
        .pw_ready (pw_ready),
        .pw_ctrl  (pw_ctrl),
        .pw_addr  (pw_addr),
        .pw_power (pw_power)
    );

    sbed_table #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .TAW         (TAW)
    ) u_table (
        .clk        (clk),
        .rst_n      (rst_n),
        .band_first (band_first_reg),
        .pw_valid   (pw_valid),
        .pw_ready   (pw_ready),
        .pw_ctrl    (pw_ctrl),
        .pw_addr    (pw_addr),
        .pw_power   (pw_power),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    // frequency and detect for the frame result
    always_comb
    begin
        freq = res.pos * hz_reg;
        det  = (CFG_W'(res.energy) > min_energy_reg) && (CFG_W'(freq) > min_freq_reg);
    end

    assign res_ready = !out_v_reg || !out_stall;

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_v_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready)
        begin
            if (res.rd)
            begin
                detect_reg <= 1'b0;
                energy_reg <= '0;
                peak_reg   <= '0;
                pos_reg    <= '0;
                freq_reg   <= '0;
                tval_reg   <= res.rd_ok ? res.data : '0;
            end
            else
            begin
                detect_reg <= det;
                energy_reg <= res.energy;
                peak_reg   <= res.peak;
                pos_reg    <= res.pos;
                freq_reg   <= freq;
                tval_reg   <= '0;
            end
        end
    end

    assign out_valid      = out_v_reg;
    assign detect         = detect_reg;
    assign band_energy    = energy_reg;
    assign peak_level     = peak_reg;
    assign peak_index     = pos_reg;
    assign peak_frequency = freq_reg;
    assign table_value    = tval_reg;

    // the peak bin is part of the band sum, which saturates far above any power
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (ENERGY_W'(peak_level) <= band_energy))
        else $error("peak power exceeds band energy");

    // a detect needs energy in the band
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && detect) |-> (band_energy != '0) && (peak_frequency != '0))
        else $error("detect without energy or frequency");

    // a mid-frame bin advances the counter by one
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !mode && !last_bin && (cnt_reg != CW'(FRAME_BINS - 1)))
        |=> (cnt_reg == CW'($past(cnt_reg) + 1'b1)))
        else $error("bin counter did not advance");

endmodule

// ===== src/sbed_power.sv =====
// Bin power pipeline: shift and magnitude, squares, saturating sum.
// Depends on sbed_pkg.
module sbed_power
    import sbed_pkg::*;
#(
    parameter int BIN_SHIFT = 9,
    parameter int TAW       = 7
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    // item entering from the top level
    input  logic                       in_load,
    output logic                       in_ready,
    input  item_ctrl_t                 in_ctrl,
    input  logic [TAW-1:0]             in_addr,
    input  logic signed [SAMPLE_W-1:0] in_real,
    input  logic signed [SAMPLE_W-1:0] in_imag,
    // item leaving toward the table stage
    output logic                       pw_valid,
    input  logic                       pw_ready,
    output item_ctrl_t                 pw_ctrl,
    output logic [TAW-1:0]             pw_addr,
    output logic [POWER_W-1:0]         pw_power
);

    logic                s1_v_reg, s2_v_reg, s3_v_reg;
    logic                s1_ready, s2_ready, s3_ready;
    item_ctrl_t          s1_ctrl_reg, s2_ctrl_reg, s3_ctrl_reg;
    logic [TAW-1:0]      s1_addr_reg, s2_addr_reg, s3_addr_reg;
    logic [SAMPLE_W-1:0] s1_mre_reg, s1_mim_reg;
    logic [SQ_W-1:0]     s2_sqre_reg, s2_sqim_reg;
    logic [POWER_W-1:0]  s3_pw_reg;

    logic signed [SAMPLE_W-1:0] sh_re, sh_im;
    logic [SAMPLE_W-1:0]        sh_re_u, sh_im_u, mag_re, mag_im;
    logic [SQ_W:0]              sq_sum;
    logic [POWER_W-1:0]         pw_next;

    // stage handshakes: a stage loads when it is empty or drains
    assign s3_ready = !s3_v_reg || pw_ready;
    assign s2_ready = !s2_v_reg || s3_ready;
    assign s1_ready = !s1_v_reg || s2_ready;
    assign in_ready = s1_ready;

    // arithmetic shift and magnitude (the most negative value maps to its unsigned magnitude)
    always_comb
    begin
        sh_re   = in_real >>> BIN_SHIFT;
        sh_im   = in_imag >>> BIN_SHIFT;
        sh_re_u = $unsigned(sh_re);
        sh_im_u = $unsigned(sh_im);
        mag_re  = sh_re[SAMPLE_W-1] ? SAMPLE_W'(~sh_re_u + 1'b1) : sh_re_u;
        mag_im  = sh_im[SAMPLE_W-1] ? SAMPLE_W'(~sh_im_u + 1'b1) : sh_im_u;
    end

    // saturating power
    always_comb
    begin
        sq_sum  = {1'b0, s2_sqre_reg} + {1'b0, s2_sqim_reg};
        pw_next = (sq_sum > (SQ_W + 1)'(POWER_MAX)) ? POWER_MAX : sq_sum[POWER_W-1:0];
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_v_reg <= in_load;
            end
            if (s2_ready)
            begin
                s2_v_reg <= s1_v_reg;
            end
            if (s3_ready)
            begin
                s3_v_reg <= s2_v_reg;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (s1_ready)
        begin
            s1_ctrl_reg <= in_ctrl;
            s1_addr_reg <= in_addr;
            s1_mre_reg  <= mag_re;
            s1_mim_reg  <= mag_im;
        end
        if (s2_ready)
        begin
            s2_ctrl_reg <= s1_ctrl_reg;
            s2_addr_reg <= s1_addr_reg;
            s2_sqre_reg <= s1_mre_reg * s1_mre_reg;
            s2_sqim_reg <= s1_mim_reg * s1_mim_reg;
        end
        if (s3_ready)
        begin
            s3_ctrl_reg <= s2_ctrl_reg;
            s3_addr_reg <= s2_addr_reg;
            s3_pw_reg   <= pw_next;
        end
    end

    assign pw_valid = s3_v_reg;
    assign pw_ctrl  = s3_ctrl_reg;
    assign pw_addr  = s3_addr_reg;
    assign pw_power = s3_pw_reg;

endmodule

// ===== src/sbed_table.sv =====
// Power table memory and frame accumulators (energy, peak, peak position).
// Depends on sbed_pkg.
module sbed_table
    import sbed_pkg::*;
#(
    parameter int TABLE_DEPTH = 128,
    parameter int TAW         = 7
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [POS_W-1:0]   band_first,
    // item from the power pipeline
    input  logic               pw_valid,
    output logic               pw_ready,
    input  item_ctrl_t         pw_ctrl,
    input  logic [TAW-1:0]     pw_addr,
    input  logic [POWER_W-1:0] pw_power,
    // result toward the output register
    output logic               res_valid,
    input  logic               res_ready,
    output result_t            res
);

    logic [POWER_W-1:0]  mem [TABLE_DEPTH];
    logic [POWER_W-1:0]  rd_data_reg;

    logic [ENERGY_W-1:0] energy_reg, energy_next;
    logic [POWER_W-1:0]  peak_reg, peak_next;
    logic [POS_W-1:0]    pos_reg, pos_next;

    logic                s4_v_reg;
    logic                s4_rd_reg, s4_rdok_reg;
    logic [ENERGY_W-1:0] s4_energy_reg;
    logic [POWER_W-1:0]  s4_peak_reg;
    logic [POS_W-1:0]    s4_pos_reg;

    logic                adv;
    logic [ENERGY_W:0]   esum;

    assign pw_ready = !s4_v_reg || res_ready;
    assign adv      = pw_valid && pw_ready;

    // accumulate the current bin; the frame result includes it
    always_comb
    begin
        esum        = {1'b0, energy_reg} + (ENERGY_W + 1)'(pw_power);
        energy_next = energy_reg;
        peak_next   = peak_reg;
        pos_next    = pos_reg;
        if (pw_ctrl.in_band)
        begin
            energy_next = (esum > {1'b0, ENERGY_MAX}) ? ENERGY_MAX : esum[ENERGY_W-1:0];
            if (pw_power > peak_reg)
            begin
                peak_next = pw_power;
                pos_next  = pw_ctrl.pos;
            end
        end
    end

    // accumulator state; reads leave it untouched
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            energy_reg <= '0;
            peak_reg   <= '0;
            pos_reg    <= BAND_FIRST_RST;
            s4_v_reg   <= 1'b0;
        end
        else
        begin
            if (adv && !pw_ctrl.rd)
            begin
                if (pw_ctrl.last)
                begin
                    energy_reg <= '0;
                    peak_reg   <= '0;
                    pos_reg    <= band_first;
                end
                else
                begin
                    energy_reg <= energy_next;
                    peak_reg   <= peak_next;
                    pos_reg    <= pos_next;
                end
            end
            if (pw_ready)
            begin
                s4_v_reg <= pw_valid && (pw_ctrl.rd || pw_ctrl.last);
            end
        end
    end

    // table: write and read sit in the same stage, so items stay in order
    always_ff @(posedge clk)
    begin
        if (adv && !pw_ctrl.rd && pw_ctrl.store)
        begin
            mem[pw_addr] <= pw_power;
        end
        if (adv && pw_ctrl.rd)
        begin
            rd_data_reg <= mem[pw_addr];
        end
    end

    // result stage payload
    always_ff @(posedge clk)
    begin
        if (pw_ready)
        begin
            s4_rd_reg     <= pw_ctrl.rd;
            s4_rdok_reg   <= pw_ctrl.rd_ok;
            s4_energy_reg <= energy_next;
            s4_peak_reg   <= peak_next;
            s4_pos_reg    <= pos_next;
        end
    end

    assign res_valid = s4_v_reg;

    always_comb
    begin
        res.rd     = s4_rd_reg;
        res.rd_ok  = s4_rdok_reg;
        res.energy = s4_energy_reg;
        res.peak   = s4_peak_reg;
        res.pos    = s4_pos_reg;
        res.data   = rd_data_reg;
    end

endmodule

// ===== sim/spectral_band_energy_detector_test.sv =====
// Self-checking testbench for spectral_band_energy_detector: directed rows, then random frames
// and table reads under three stall profiles, checked against an in-bench predictor.
// Depends on src/sbed_pkg.sv and src/spectral_band_energy_detector.sv.
`timescale 1ns / 1ps

module spectral_band_energy_detector_test;
    import sbed_pkg::*;

    localparam int TABLE_ENTRIES = 128;
    localparam int FRAME_LEN     = 512;
    localparam int SHIFT_BITS    = 9;
    localparam logic [2:0] CFG_UNUSED = 3'd7;

    // Register setting per random sub-phase: 0 narrow band, 1 full band, 2 top bin only,
    // 3 empty or reversed band, 4 band wider than the table
    localparam int SETTING_KINDS [10] = '{0, 3, 0, 1, 4, 0, 2, 1, 0, 3};
    localparam int SETTING_ITEMS [10] = '{100, 100, 100, 110, 100, 100, 0, 110, 100, 100};

    typedef struct packed {
        logic                detect;
        logic [ENERGY_W-1:0] energy;
        logic [POWER_W-1:0]  peak;
        logic [POS_W-1:0]    pos;
        logic [FREQ_W-1:0]   freq;
        logic [POWER_W-1:0]  value;
    } band_report_t;

    typedef enum logic {
        STEP_ITEM,
        STEP_WRITE
    } step_kind_t;

    typedef struct packed {
        step_kind_t   kind;
        logic         md;
        logic [15:0]  re;
        logic [15:0]  im;
        logic         lb;
        logic [6:0]   ridx;
        logic [2:0]   reg_idx;
        logic [31:0]  reg_data;
        logic         typed;
        band_report_t want;
    } plan_row_t;

    // DUT signals
    logic                       clk;
    logic                       rst_n;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [2:0]                 cfg_index;
    logic [CFG_W-1:0]           cfg_data;
    logic                       in_valid;
    logic                       in_stall;
    logic                       mode;
    logic signed [SAMPLE_W-1:0] bin_real;
    logic signed [SAMPLE_W-1:0] bin_imag;
    logic                       last_bin;
    logic [6:0]                 read_index;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic                       detect;
    logic [ENERGY_W-1:0]        band_energy;
    logic [POWER_W-1:0]         peak_level;
    logic [POS_W-1:0]           peak_index;
    logic [FREQ_W-1:0]          peak_frequency;
    logic [POWER_W-1:0]         table_value;

    // Predictor copy of registers and frame state
    int unsigned pr_first      = BAND_FIRST_RST;
    int unsigned pr_end        = BAND_END_RST;
    int unsigned pr_min_energy = MIN_ENERGY_RST;
    int unsigned pr_min_freq   = MIN_FREQ_RST;
    int unsigned pr_hz         = HZ_PER_BIN_RST;
    int unsigned bin_count     = 0;
    int unsigned energy_acc    = 0;
    int unsigned peak_acc      = 0;
    logic [POS_W-1:0] peak_at  = BAND_FIRST_RST;
    logic [POWER_W-1:0] power_copy [TABLE_ENTRIES];
    bit entry_written [TABLE_ENTRIES];

    band_report_t expected_reports [$];
    plan_row_t    directed_plan [$];
    int send_idle_pct  = 34;
    int recv_idle_pct  = 82;
    int items_sent     = 0;
    int mismatch_count = 0;

    spectral_band_energy_detector uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .mode           (mode),
        .bin_real       (bin_real),
        .bin_imag       (bin_imag),
        .last_bin       (last_bin),
        .read_index     (read_index),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .detect         (detect),
        .band_energy    (band_energy),
        .peak_level     (peak_level),
        .peak_index     (peak_index),
        .peak_frequency (peak_frequency),
        .table_value    (table_value)
    );

    // 2 ns clock
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Run limit
    initial
    begin
        #1000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Arithmetic shift by the bin shift, then square of the magnitude
    function automatic int unsigned shifted_square(input logic signed [SAMPLE_W-1:0] raw);
        logic signed [SAMPLE_W-1:0] s;
        int mag;
        s = raw >>> SHIFT_BITS;
        mag = (s < 0) ? -int'(s) : int'(s);
        return mag * mag;
    endfunction

    // Advance the predictor by one accepted item; returns 1 when a result is due
    function automatic bit predict_report(input logic md, input logic signed [SAMPLE_W-1:0] re,
                                          input logic signed [SAMPLE_W-1:0] im, input logic lb,
                                          input logic [6:0] ridx, output band_report_t rpt);
        int unsigned p;
        int unsigned off;
        longint unsigned freq;
        rpt = '0;
        if (md)
        begin
            rpt.value = power_copy[ridx];
            return 1'b1;
        end
        if (bin_count >= pr_first && bin_count < pr_end)
        begin
            p = shifted_square(re) + shifted_square(im);
            if (p > POWER_MAX)
                p = POWER_MAX;
            off = bin_count - pr_first;
            if (off < TABLE_ENTRIES)
            begin
                power_copy[off] = p[POWER_W-1:0];
                entry_written[off] = 1'b1;
            end
            energy_acc += p;
            if (energy_acc > ENERGY_MAX)
                energy_acc = ENERGY_MAX;
            // strict compare: the first of equal powers keeps the peak
            if (p > peak_acc)
            begin
                peak_acc = p;
                peak_at  = bin_count[POS_W-1:0];
            end
        end
        if (lb)
        begin
            freq = (longint'(peak_at) * pr_hz) & ((64'd1 << FREQ_W) - 1);
            rpt.detect = (energy_acc > pr_min_energy) && (freq > pr_min_freq);
            rpt.energy = energy_acc[ENERGY_W-1:0];
            rpt.peak   = peak_acc[POWER_W-1:0];
            rpt.pos    = peak_at;
            rpt.freq   = freq[FREQ_W-1:0];
            // frame restart; peak position reloads from the current band start
            bin_count  = 0;
            energy_acc = 0;
            peak_acc   = 0;
            peak_at    = pr_first[POS_W-1:0];
            return 1'b1;
        end
        // no last bin: counter wraps and the frame keeps accumulating
        bin_count++;
        if (bin_count >= FRAME_LEN)
            bin_count = 0;
        return 1'b0;
    endfunction

    function automatic logic [15:0] random_part();
        logic [15:0] r;
        r = 16'($urandom);
        case ($urandom_range(0, 9))
            0: r = 16'h8000;
            1: r = 16'h7FFF;
            2: r = 16'h0000;
            3: r = 16'hFFFF;
            4: r = {{7{r[8]}}, r[8:0]};   // 0 or -1 after the shift
            default: ;
        endcase
        return r;
    endfunction

    // Only entries written by some frame are read back
    function automatic logic [6:0] pick_entry();
        logic [6:0] idx;
        idx = 7'($urandom_range(0, TABLE_ENTRIES - 1));
        while (!entry_written[idx])
            idx = 7'($urandom_range(0, TABLE_ENTRIES - 1));
        return idx;
    endfunction

    function automatic logic [31:0] threshold(input int sel, input int unsigned span);
        case (sel)
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(0, span);
            default: return $urandom;
        endcase
    endfunction

    function automatic plan_row_t bin_step(input logic [15:0] re, input logic [15:0] im,
                                           input logic lb);
        plan_row_t r;
        r = '0;
        r.kind = STEP_ITEM;
        r.re = re;
        r.im = im;
        r.lb = lb;
        return r;
    endfunction

    function automatic plan_row_t read_step(input logic [6:0] idx, input logic lb);
        plan_row_t r;
        r = '0;
        r.kind = STEP_ITEM;
        r.md = 1'b1;
        r.ridx = idx;
        r.lb = lb;
        r.re = 16'h5A5A;
        return r;
    endfunction

    function automatic plan_row_t write_step(input logic [2:0] idx, input logic [31:0] data);
        plan_row_t r;
        r = '0;
        r.kind = STEP_WRITE;
        r.reg_idx = idx;
        r.reg_data = data;
        return r;
    endfunction

    function automatic plan_row_t with_report(input plan_row_t r, input band_report_t w);
        plan_row_t t;
        t = r;
        t.typed = 1'b1;
        t.want = w;
        return t;
    endfunction

    // Present one item, hold it through stalls, then predict it
    task automatic send_item(input logic md, input logic [15:0] re, input logic [15:0] im,
                             input logic lb, input logic [6:0] ridx, input bit typed,
                             input band_report_t want);
        band_report_t rpt;
        bit has;
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        mode       <= md;
        bin_real   <= re;
        bin_imag   <= im;
        last_bin   <= lb;
        read_index <= ridx;
        do
            @(posedge clk);
        while (in_stall);
        items_sent++;
        has = predict_report(md, re, im, lb, ridx, rpt);
        if (has)
            expected_reports.push_back(typed ? want : rpt);
    endtask

    task automatic send_bin(input logic lb);
        send_item(1'b0, random_part(), random_part(), lb, 7'($urandom), 1'b0, '0);
    endtask

    task automatic send_read();
        send_item(1'b1, 16'($urandom), 16'($urandom), 1'($urandom), pick_entry(), 1'b0, '0);
    endtask

    // Stop sending, wait for every result, then let the pipeline empty
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_reports.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic write_register(input logic [2:0] idx, input logic [31:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_BAND_FIRST: pr_first      = data[8:0];
            CFG_BAND_END:   pr_end        = data[9:0];
            CFG_MIN_ENERGY: pr_min_energy = data;
            CFG_MIN_FREQ:   pr_min_freq   = data;
            CFG_HZ_PER_BIN: pr_hz         = data[15:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Write all registers for one sub-phase; band registers carry junk above their width
    task automatic apply_setting(input int kind, input int s);
        int unsigned first;
        int unsigned stop_bin;
        logic [31:0] e_lim;
        logic [31:0] f_lim;
        logic [15:0] hz;
        case (kind)
            0:
            begin
                first = $urandom_range(0, 15);
                stop_bin = first + $urandom_range(1, 40);
            end
            1:
            begin
                first = 0;
                stop_bin = FRAME_LEN;
            end
            2:
            begin
                first = FRAME_LEN - 1;
                stop_bin = FRAME_LEN;
            end
            3:
            begin
                first = $urandom_range(1, 60);
                stop_bin = $urandom_range(0, first);
            end
            default:
            begin
                first = 0;
                stop_bin = $urandom_range(TABLE_ENTRIES + 1, FRAME_LEN - 1);
            end
        endcase
        e_lim = threshold(s % 4, 40000);
        f_lim = threshold((s + 1) % 4, 60000);
        case ((s + 2) % 4)
            0: hz = 16'h0000;
            1: hz = 16'hFFFF;
            2: hz = 16'($urandom_range(0, 3000));
            default: hz = 16'($urandom);
        endcase
        settle();
        write_register(CFG_BAND_FIRST, ($urandom & ~32'h1FF) | first);
        write_register(CFG_BAND_END, ($urandom & ~32'h3FF) | stop_bin);
        write_register(CFG_MIN_ENERGY, e_lim);
        write_register(CFG_MIN_FREQ, f_lim);
        write_register(CFG_HZ_PER_BIN, ($urandom & ~32'hFFFF) | hz);
        if (s % 3 == 0)
            write_register(CFG_UNUSED, $urandom);
    endtask

    // One frame of bins with reads mixed in; an open frame carries on into the next call
    task automatic run_frame(input int len, input bit close);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                send_read();
            send_bin(close && (i == len - 1));
        end
    endtask

    task automatic run_traffic(input int kind, input int budget);
        int stop_at;
        int len;
        stop_at = items_sent + budget;
        if (kind == 2)
        begin
            // frame with no last bin in time: counter wraps past the top bin
            run_frame(FRAME_LEN + $urandom_range(1, 40), 1'b1);
            repeat (8) send_read();
        end
        else
        begin
            while (items_sent < stop_at)
            begin
                if ((kind == 1 || kind == 4) && $urandom_range(0, 4) == 0)
                    len = $urandom_range(TABLE_ENTRIES + 1, 200);
                else
                    len = $urandom_range(1, 60);
                run_frame(len, $urandom_range(0, 9) != 0);
                repeat ($urandom_range(0, 3)) send_read();
            end
        end
    endtask

    // Receiver stall
    always @(negedge clk)
        out_stall <= rst_n && ($urandom_range(0, 99) < recv_idle_pct);

    task automatic check_field(input string name, input longint unsigned want,
                               input longint unsigned got);
        if (want != got)
        begin
            $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // Result checker
    always @(posedge clk)
    begin
        band_report_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_reports.size() == 0)
            begin
                $display("%0t ns: result item with none expected: detect %0d energy %0d",
                         $time, detect, band_energy);
                $display("    peak %0d index %0d freq %0d value %0d",
                         peak_level, peak_index, peak_frequency, table_value);
                mismatch_count++;
            end
            else
            begin
                want = expected_reports.pop_front();
                check_field("detect", want.detect, detect);
                check_field("band_energy", want.energy, band_energy);
                check_field("peak_level", want.peak, peak_level);
                check_field("peak_index", want.pos, peak_index);
                check_field("peak_frequency", want.freq, peak_frequency);
                check_field("table_value", want.value, table_value);
            end
        end
    end

    // Stimulus
    initial
    begin
        rst_n      = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        in_valid   = 1'b0;
        mode       = 1'b0;
        bin_real   = '0;
        bin_imag   = '0;
        last_bin   = 1'b0;
        read_index = '0;
        foreach (power_copy[i])
        begin
            power_copy[i] = '0;
            entry_written[i] = 1'b0;
        end
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed rows: outside-band frame at reset, then band from bin 0
        directed_plan.push_back(with_report(bin_step(16'h0000, 16'h0000, 1'b1),
                                            '{1'b0, 23'd0, 14'd0, 9'd10, 25'd10000, 14'd0}));
        directed_plan.push_back(write_step(CFG_BAND_FIRST, 32'hFFFF_FE00));
        directed_plan.push_back(bin_step(16'h7FFF, 16'h7FFF, 1'b0));
        directed_plan.push_back(bin_step(16'h8000, 16'h8000, 1'b0));
        directed_plan.push_back(bin_step(16'h8000, 16'h8000, 1'b0));   // tie, first stays
        directed_plan.push_back(bin_step(16'hFFFF, 16'hFFFF, 1'b0));   // -1 stays -1
        directed_plan.push_back(bin_step(16'h01FF, 16'hFE00, 1'b0));
        directed_plan.push_back(bin_step(16'hFE00, 16'h0200, 1'b0));
        directed_plan.push_back(with_report(read_step(7'd1, 1'b0),
                                            '{1'b0, 23'd0, 14'd0, 9'd0, 25'd0, 14'd8192}));
        directed_plan.push_back(read_step(7'd0, 1'b0));
        directed_plan.push_back(bin_step(16'h0000, 16'h0000, 1'b1));
        directed_plan.push_back(read_step(7'd3, 1'b0));
        // all-zero frame: peak index is the band start
        directed_plan.push_back(with_report(bin_step(16'h0000, 16'h0000, 1'b1),
                                            '{1'b0, 23'd0, 14'd0, 9'd0, 25'd0, 14'd0}));
        directed_plan.push_back(with_report(read_step(7'd2, 1'b1),
                                            '{1'b0, 23'd0, 14'd0, 9'd0, 25'd0, 14'd8192}));
        directed_plan.push_back(write_step(CFG_HZ_PER_BIN, 32'hFFFF_FFFF));
        directed_plan.push_back(bin_step(16'h7FFF, 16'h8000, 1'b0));
        directed_plan.push_back(bin_step(16'h8000, 16'h7FFF, 1'b1));
        directed_plan.push_back(read_step(7'd0, 1'b1));
        directed_plan.push_back(read_step(7'd1, 1'b0));
        foreach (directed_plan[i])
        begin
            if (directed_plan[i].kind == STEP_WRITE)
            begin
                settle();
                write_register(directed_plan[i].reg_idx, directed_plan[i].reg_data);
            end
            else
            begin
                send_item(directed_plan[i].md, directed_plan[i].re, directed_plan[i].im,
                          directed_plan[i].lb, directed_plan[i].ridx,
                          directed_plan[i].typed, directed_plan[i].want);
            end
        end

        // Random part: receiver-heavy idling, then sender-heavy, then none
        for (int s = 0; s < 10; s++)
        begin
            if (s < 4)
            begin
                send_idle_pct = 34;
                recv_idle_pct = 82;
            end
            else if (s < 7)
            begin
                send_idle_pct = 82;
                recv_idle_pct = 34;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            apply_setting(SETTING_KINDS[s], s);
            run_traffic(SETTING_KINDS[s], SETTING_ITEMS[s]);
        end

        settle();
        repeat (20) @(posedge clk);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
